// ----- hw/rtl/cdnq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnq_pkg: shared types and constants for the deadline notification queue
// Sizes, command codes, the queue cell entry and control/status bundles.
// ----------------------------------------------------------------------------
package cdnq_pkg;

  localparam int CLIENTS   = 16;
  localparam int TIME_BITS = 48;
  localparam int IDX_W     = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  localparam logic [TIME_BITS-1:0] TMAX = '1;

  typedef enum logic [1:0] {
    FUNC_RESET_ADD = 2'd0,
    FUNC_ADD       = 2'd1,
    FUNC_RESET     = 2'd2,
    FUNC_TICK      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_DRAIN
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_UPDATE,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    logic                 valid;
    logic [IDX_W-1:0]     id;
    logic [TIME_BITS-1:0] dl;
  } entry_t;

  typedef struct packed {
    cell_op_t             op;
    logic [IDX_W-1:0]     id;
    logic [TIME_BITS-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic             head_le;
    logic             next_le;
    logic [IDX_W-1:0] head_id;
    logic             full;
  } chain_stat_t;

  // queue index to 4-bit client number
  function automatic logic [3:0] to_client(logic [IDX_W-1:0] id);
    logic [63:0] w;
    w = 64'(id);
    return w[3:0];
  endfunction

endpackage

// ----- hw/rtl/cdnq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnq_cell: one slot of the ordered queue
// Holds a client id and its deadline; shifts with its neighbors on
// remove, insert and pop, and compares its deadline against a broadcast key.
// ----------------------------------------------------------------------------
module cdnq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  cdnq_pkg::cell_ctrl_t ctrl_i,
  input  cdnq_pkg::entry_t    prev_i,
  input  cdnq_pkg::entry_t    next_i,
  input  logic                prev_le_i,
  input  logic                hit_i,
  input  logic                le_tail_i,
  output cdnq_pkg::entry_t    entry_o,
  output logic                le_o,
  output logic                hit_o,
  output logic                le_tail_o
);
  import cdnq_pkg::*;

  entry_t e_r, e_nxt;
  logic   match;

  assign entry_o   = e_r;
  assign match     = e_r.valid && (e_r.id == ctrl_i.id);
  assign le_o      = e_r.valid && (e_r.dl <= ctrl_i.key);
  assign hit_o     = hit_i || match;
  assign le_tail_o = le_tail_i || le_o;

  always_comb begin
    e_nxt = e_r;
    case (ctrl_i.op)
      CELL_UPDATE: begin
        if (match) e_nxt.dl = ctrl_i.key;
      end
      CELL_REMOVE: begin
        // everything from the matching slot on moves one toward the head
        if (hit_i || match) e_nxt = next_i;
      end
      CELL_INSERT: begin
        if (le_tail_i || le_o) begin
          e_nxt = e_r;
        end else if (prev_le_i) begin
          e_nxt.valid = 1'b1;
          e_nxt.id    = ctrl_i.id;
          e_nxt.dl    = ctrl_i.key;
        end else begin
          e_nxt = prev_i;
        end
      end
      CELL_POP: begin
        e_nxt = next_i;
      end
      default: begin
        e_nxt = e_r;
      end
    endcase
  end

  // only the valid bit is reset; id and deadline are don't-care while empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
    end else begin
      e_r.valid <= e_nxt.valid;
    end
    e_r.id <= e_nxt.id;
    e_r.dl <= e_nxt.dl;
  end

endmodule

// ----- hw/rtl/cdnq_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnq_chain: row of queue cells
// Wires neighbor links and the two ripple chains (match from head, compare
// from tail), and reports head status to the controller.
// ----------------------------------------------------------------------------
module cdnq_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdnq_pkg::cell_ctrl_t  ctrl_i,
  output cdnq_pkg::chain_stat_t stat_o
);
  import cdnq_pkg::*;

  entry_t ent [CLIENTS];
  logic   le  [CLIENTS];
  logic   hit [CLIENTS+1];
  logic   tl  [CLIENTS+1];

  assign hit[0]       = 1'b0;
  assign tl[CLIENTS]  = 1'b0;

  for (genvar i = 0; i < CLIENTS; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_le;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_le = 1'b1;
    end else begin : g_body
      assign prev_e  = ent[i-1];
      assign prev_le = le[i-1];
    end

    if (i == CLIENTS - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = ent[i+1];
    end

    cdnq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl_i    (ctrl_i),
      .prev_i    (prev_e),
      .next_i    (next_e),
      .prev_le_i (prev_le),
      .hit_i     (hit[i]),
      .le_tail_i (tl[i+1]),
      .entry_o   (ent[i]),
      .le_o      (le[i]),
      .hit_o     (hit[i+1]),
      .le_tail_o (tl[i])
    );
  end

  assign stat_o.head_le = le[0];
  assign stat_o.head_id = ent[0].id;
  assign stat_o.full    = ent[CLIENTS-1].valid;

  if (CLIENTS > 1) begin : g_next
    assign stat_o.next_le = le[1];
  end else begin : g_nonext
    assign stat_o.next_le = 1'b0;
  end

endmodule

// ----- hw/rtl/client_deadline_notification_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_deadline_notification_queue: per-client deadline timer with queue
// Keeps a millisecond clock, per-client deadlines and a deadline-ordered
// queue of pending clients, and notifies clients whose deadline has passed.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_stall) carry a command: func, client, delay_ms.
//   Reset-then-add and add compute the client's new saturating deadline and
//   move the client to its sorted place in the queue (after equal deadlines).
//   Reset only rewrites the deadline of a known client; the queue is left as
//   it is. Tick advances the clock by 1 ms and drains the queue head.
//   Output beats (out_valid/out_stall) carry one notified client each; the
//   final beat caused by a tick has out_last_flag set.
// Sequencing:
//   Add commands run in three steps: accept, remove sweep and insert sweep
//   over the cell row. Reset and ignored commands finish in the accept cycle.
//   A tick enters the drain, which pops one notified client per cycle at the
//   head cell while the output register is free, pausing while out_stall holds a beat.
//   One command is worked on at a time; in_stall is high while busy.
// Reset:
//   Clock, queue and known marks clear; no clearing pass is needed.
// Stall:
//   A held output beat stays put; the drain pauses until it is taken.
// ----------------------------------------------------------------------------
module client_deadline_notification_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_client,
  input  logic [31:0] in_delay_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_notified_client,
  output logic        out_last_flag
);
  import cdnq_pkg::*;

  // control state
  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r;
  logic [CLIENTS-1:0]   known_r;
  logic                 out_valid_r;

  // payload
  logic [TIME_BITS-1:0] deadline_r [CLIENTS];
  logic [TIME_BITS-1:0] key_r;
  logic [IDX_W-1:0]     client_r;
  logic [3:0]           out_client_r;
  logic                 out_last_r;

  // decode of the incoming beat
  func_t                func;
  logic                 accept;
  logic                 in_range;
  logic [63:0]          client_w;
  logic [IDX_W-1:0]     idx;
  logic                 is_add;
  logic [TIME_BITS-1:0] base_dl;
  logic [TIME_BITS:0]   sum_dl;
  logic [TIME_BITS-1:0] new_dl;

  cell_ctrl_t           ctrl;
  chain_stat_t          stat;
  logic                 out_free;
  logic                 pop;

  assign func     = func_t'(in_func);
  assign accept   = in_valid && !in_stall;
  assign client_w = 64'(in_client);
  assign in_range = client_w < 64'(CLIENTS);
  assign idx      = client_w[IDX_W-1:0];
  assign is_add   = (func == FUNC_RESET_ADD) || (func == FUNC_ADD);

  // base is now for a fresh client or reset-add, else the stored deadline
  assign base_dl = (known_r[idx] && (func == FUNC_ADD)) ? deadline_r[idx] : now_r;
  assign sum_dl  = {1'b0, base_dl} + (TIME_BITS+1)'(in_delay_ms);
  assign new_dl  = sum_dl[TIME_BITS] ? TMAX : sum_dl[TIME_BITS-1:0];

  assign in_stall = (state_r != S_IDLE);

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_DRAIN) && stat.head_le && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (func == FUNC_TICK)          state_nxt = S_DRAIN;
          else if (is_add && in_range)    state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: state_nxt = S_INSERT;
      S_INSERT: state_nxt = S_IDLE;
      S_DRAIN: begin
        if (!stat.head_le) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell row control
  always_comb begin
    ctrl.op  = CELL_HOLD;
    ctrl.id  = client_r;
    ctrl.key = now_r;
    case (state_r)
      S_IDLE: begin
        ctrl.id = idx;
        if (accept && (func == FUNC_RESET) && in_range && known_r[idx]) begin
          ctrl.op = CELL_UPDATE;
        end
      end
      S_REMOVE: ctrl.op = CELL_REMOVE;
      S_INSERT: begin
        ctrl.key = key_r;
        if (!stat.full) ctrl.op = CELL_INSERT;
      end
      S_DRAIN: begin
        if (pop) ctrl.op = CELL_POP;
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  cdnq_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      known_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (func == FUNC_TICK) && (now_r != TMAX)) begin
        now_r <= now_r + 1'b1;
      end
      if (accept && is_add && in_range) begin
        known_r[idx] <= 1'b1;
      end
      if (pop)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (is_add) begin
        deadline_r[idx] <= new_dl;
      end else if ((func == FUNC_RESET) && known_r[idx]) begin
        deadline_r[idx] <= now_r;
      end
    end
    if (accept && is_add) begin
      key_r    <= new_dl;
      client_r <= idx;
    end
    if (pop) begin
      out_client_r <= to_client(stat.head_id);
      out_last_r   <= !stat.next_le;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_notified_client = out_client_r;
  assign out_last_flag       = out_last_r;

endmodule

// ----- hw/rtl/cdnq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnq_checker: port-level checks for the deadline notification queue
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module cdnq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_notified_client,
  input logic       out_last_flag
);
  import cdnq_pkg::*;

  // held output beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // held output beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_notified_client) && $stable(out_last_flag))
    else $error("output payload changed while stalled");

  // a tick always occupies the block for the drain
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_TICK) |=> in_stall)
    else $error("tick accepted without drain phase");

  // only ticks start notifications
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func != FUNC_TICK) |=> !$rose(out_valid))
    else $error("notification after non-tick command");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind client_deadline_notification_queue cdnq_checker u_cdnq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_func             (in_func),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_notified_client (out_notified_client),
  .out_last_flag       (out_last_flag)
);

// ----- dv/client_deadline_notification_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_deadline_notification_queue_tb: self-checking bench for the queue
// Drives directed and random commands through the valid/stall input, keeps
// its own copy of the clock, per-client deadlines and the ordered queue, and
// checks every notification beat against the predicted sequence.
// ----------------------------------------------------------------------------
module client_deadline_notification_queue_tb;
  import cdnq_pkg::*;

  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT  = 500000;
  // longest tick pops all 16 clients; leave room for receiver stalls
  localparam int DRAIN_CYCLES = 60;

  // one expected notification beat
  typedef struct packed {
    logic [3:0] client;
    logic       last;
  } notice_t;

  // directed row; want_n < 0 means the row is only checked by the predictor
  typedef struct packed {
    func_t       f;
    logic [3:0]  c;
    logic [31:0] d;
    int          want_n;
    logic [3:0]  want_first;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [3:0]  in_client;
  logic [31:0] in_delay_ms;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_notified_client;
  logic        out_last_flag;

  client_deadline_notification_queue u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_client           (in_client),
    .in_delay_ms         (in_delay_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_notified_client (out_notified_client),
    .out_last_flag       (out_last_flag)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: millisecond clock, deadlines, known marks and the queue
  // of pending clients, head at index 0.
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0] ms_clock;
  logic [TIME_BITS-1:0] due_at [CLIENTS];
  logic                 seen   [CLIENTS];
  logic [3:0]           wait_line [$];

  notice_t notices_due [$];   // beats still owed by the block, oldest first
  int      errors;

  // Applies one command to the predictor state; any notifications it causes
  // are appended to got.
  function automatic void predict_command(input func_t f, input logic [3:0] c,
                                          input logic [31:0] d,
                                          ref notice_t got[$]);
    logic [TIME_BITS:0] sum;
    int                 pos;
    notice_t            nb;
    if (f == FUNC_TICK) begin
      if (ms_clock < TMAX) ms_clock = ms_clock + 1'b1;
      // drain walks from the head only, so a reset entry can block the rest
      while (wait_line.size() > 0 && due_at[wait_line[0]] <= ms_clock) begin
        nb.client = wait_line[0];
        nb.last   = 1'b0;
        wait_line.delete(0);
        got.insert(got.size(), nb);
      end
      if (got.size() > 0) got[got.size()-1].last = 1'b1;
      return;
    end
    if (f == FUNC_RESET) begin
      // unknown client: no effect; known client keeps its queue slot
      if (seen[c]) due_at[c] = ms_clock;
      return;
    end
    if (!seen[c]) begin
      seen[c]   = 1'b1;
      due_at[c] = ms_clock;
    end
    if (f == FUNC_RESET_ADD) due_at[c] = ms_clock;
    sum = {1'b0, due_at[c]} + {{(TIME_BITS-31){1'b0}}, d};
    due_at[c] = (sum > {1'b0, TMAX}) ? TMAX : sum[TIME_BITS-1:0];
    for (int i = 0; i < wait_line.size(); i++) begin
      if (wait_line[i] == c) begin
        wait_line.delete(i);
        break;
      end
    end
    // go in after the last entry at or below the new deadline
    if (wait_line.size() < CLIENTS) begin
      pos = wait_line.size();
      while (pos > 0 && due_at[wait_line[pos-1]] > due_at[c]) pos--;
      wait_line.insert(pos, c);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. A new beat follows an
  // accepted one in the same step when the burst goes on, so valid is never
  // dropped and raised within one step.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  task automatic push_command(input func_t f, input logic [3:0] c, input logic [31:0] d,
                              input int want_n, input logic [3:0] want_first);
    notice_t got [$];
    while (gap_left > 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_client   <= c;
    in_delay_ms <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    predict_command(f, c, d, got);
    if (want_n >= 0 &&
        (got.size() != want_n || (want_n > 0 && got[0].client != want_first))) begin
      errors++;
      $display("%0t: directed row func %0d client %0d: expected %0d beats first %0d, got %0d",
               $time, f, c, want_n, want_first, got.size());
    end
    foreach (got[i]) notices_due.insert(notices_due.size(), got[i]);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      // zero gap keeps some stretches fully back to back
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 4);
    if (r < 8) return $urandom_range(0, 40);
    if (r == 8) return $urandom;
    return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches at random between none, light random,
  // periodic and heavy random.
  // --------------------------------------------------------------------------
  logic [1:0] stall_mode = 2'd0;
  int         stall_span = 40;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= (stall_span % 3 == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result check: every taken beat against the oldest expectation.
  // --------------------------------------------------------------------------
  notice_t seen_beat;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (notices_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got client %0d last %0b",
                 $time, out_notified_client, out_last_flag);
      end else begin
        seen_beat = notices_due[0];
        notices_due.delete(0);
        if (out_notified_client !== seen_beat.client) begin
          errors++;
          $display("%0t: notified_client mismatch, expected %0d, got %0d",
                   $time, seen_beat.client, out_notified_client);
        end
        if (out_last_flag !== seen_beat.last) begin
          errors++;
          $display("%0t: last_flag mismatch, expected %0b, got %0b",
                   $time, seen_beat.last, out_last_flag);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed script. Clock starts at 0 and each tick adds 1 ms; the comments
  // give the clock after the row.
  // --------------------------------------------------------------------------
  step_row_t script [0:20] = '{
    '{FUNC_TICK,      4'd0,  32'd0,         0,  4'd0},  // empty queue, now 1
    '{FUNC_RESET,     4'd3,  32'd0,         0,  4'd0},  // unknown client, no effect
    '{FUNC_RESET_ADD, 4'd0,  32'd0,        -1,  4'd0},  // deadline 1
    '{FUNC_TICK,      4'd0,  32'd0,         1,  4'd0},  // now 2, client 0 due
    '{FUNC_ADD,       4'd15, 32'd2,        -1,  4'd0},  // first use: 2 + 2
    '{FUNC_ADD,       4'd7,  32'd1,        -1,  4'd0},  // 3
    '{FUNC_ADD,       4'd9,  32'd1,        -1,  4'd0},  // 3, lands after 7
    '{FUNC_RESET_ADD, 4'd15, 32'hFFFF_FFFF, -1, 4'd0},  // largest delay
    '{FUNC_TICK,      4'd0,  32'd0,         2,  4'd7},  // now 3, 7 then 9
    '{FUNC_ADD,       4'd1,  32'd5,        -1,  4'd0},  // 8, ahead of 15
    '{FUNC_RESET,     4'd15, 32'hFFFF_FFFF, 0,  4'd0},  // queued: 15 now 3, stays last
    '{FUNC_ADD,       4'd2,  32'd2,        -1,  4'd0},  // 5 into unordered queue
    '{FUNC_ADD,       4'd4,  32'd0,        -1,  4'd0},  // 3, after 15
    '{FUNC_TICK,      4'd0,  32'd0,         0,  4'd0},  // now 4, head 1 blocks
    '{FUNC_RESET_ADD, 4'd1,  32'd0,        -1,  4'd0},  // 1 moves behind 4
    '{FUNC_TICK,      4'd0,  32'd0,         4,  4'd15}, // now 5, whole queue
    '{FUNC_ADD,       4'd8,  32'hFFFF_FFFF, -1, 4'd0},
    '{FUNC_ADD,       4'd8,  32'hFFFF_FFFF, -1, 4'd0},  // beyond 32 bits
    '{FUNC_ADD,       4'd11, 32'd0,        -1,  4'd0},  // 5, ahead of 8
    '{FUNC_RESET,     4'd8,  32'd0,        -1,  4'd0},  // 8 back to now
    '{FUNC_TICK,      4'd0,  32'd0,         2,  4'd11}  // now 6, 11 then 8
  };

  // Watchdog: ends a hung run.
  int cycles;

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  int    sent;
  func_t pick;

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FUNC_TICK;
    in_client   = 4'd0;
    in_delay_ms = 32'd0;
    errors      = 0;
    burst_left  = 4;
    gap_left    = 0;
    ms_clock    = '0;
    for (int i = 0; i < CLIENTS; i++) begin
      due_at[i] = '0;
      seen[i]   = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      push_command(script[i].f, script[i].c, script[i].d, script[i].want_n,
                   script[i].want_first);

    // Random part: mostly adds and ticks with short delays so the queue both
    // fills and drains; now and then every client is loaded with a zero
    // delay so that one tick notifies all sixteen.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        for (int k = 0; k < CLIENTS; k++) begin
          push_command(FUNC_RESET_ADD, 4'(k), 32'd0, -1, 4'd0);
        end
        push_command(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom, -1, 4'd0);
        sent += CLIENTS + 1;
      end else begin
        case ($urandom_range(0, 9))
          0:       pick = FUNC_RESET;
          1, 2, 3: pick = FUNC_TICK;
          4, 5, 6: pick = FUNC_ADD;
          default: pick = FUNC_RESET_ADD;
        endcase
        push_command(pick, 4'($urandom_range(0, 15)), pick_delay(), -1, 4'd0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    wait (notices_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && notices_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
